/* sv/rgbm_pkg.sv */
// shared constants, payload types and control structs for the led matrix scan driver
package rgbm_pkg;

	// panel geometry and modulation depth
	localparam int PANEL_WIDTH  = 64;
	localparam int PANEL_HEIGHT = 64;
	localparam int HALF_ROWS    = 32;
	localparam int PLANE_COUNT  = 8;

	// derived widths
	localparam int COL_W     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
	localparam int ROW_W     = 5;
	localparam int PLANE_W   = 3;
	localparam int CNT_W     = 23;
	localparam int UNIT_W    = 16;
	localparam int MEM_DEPTH = HALF_ROWS * PANEL_WIDTH;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int PIX_W     = 24;

	localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd10;

	// item function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_PIXEL = 2'd1;
	localparam logic [1:0] FUNC_FILL  = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [7:0]  red_level;
		logic [7:0]  green_level;
		logic [7:0]  blue_level;
	} in_item_t;

	typedef struct packed {
		logic       upper_red;
		logic       upper_green;
		logic       upper_blue;
		logic       lower_red;
		logic       lower_green;
		logic       lower_blue;
		logic       shift_pulse;
		logic       latch_strobe;
		logic       output_disable;
		logic [4:0] row_address;
	} out_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// controller to datapath
	typedef struct packed {
		logic tick_shift;
		logic tick_latch;
		logic tick_disp;
		logic next_row;
		logic pix_wr;
		logic fill_load;
		logic sweep_wr;
		logic load_s1;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic col_last;
		logic unit_zero;
		logic cd_last;
		logic cd_nonzero;
		logic sweep_last;
	} dp_stat_t;

	// linear address of a pixel inside one half of the panel
	function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(PANEL_WIDTH)) + ADDR_W'(col);
	endfunction

endpackage

/* sv/rgbm_ram.sv */
// generic simple dual port ram with registered read
module rgbm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/rgbm_ctrl.sv */
// controller: handshake, store sweep sequencing and scan phase state machine
module rgbm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  rgbm_pkg::dp_stat_t   stat,
	output rgbm_pkg::ctrl_cmd_t  cmd
);
	import rgbm_pkg::*;

	typedef enum logic [1:0] {M_CLEAR, M_RUN, M_FILL} mode_t;
	typedef enum logic [1:0] {PH_SHIFT, PH_LATCH, PH_DISPLAY} phase_t;

	mode_t  mode_q;
	phase_t phase_q;
	logic   s1_valid_q;
	logic   out_valid_q;
	logic   out_free;
	logic   acc;
	logic   tick;

	// handshake and command decode
	always_comb begin
		out_free = !out_valid_q || out_ready;
		in_ready = (mode_q == M_RUN) && (!s1_valid_q || out_free);
		acc      = in_valid && in_ready;
		tick     = acc && (func == FUNC_TICK);

		cmd            = '0;
		cmd.tick_shift = tick && (phase_q == PH_SHIFT);
		cmd.tick_latch = tick && (phase_q == PH_LATCH);
		cmd.tick_disp  = tick && (phase_q == PH_DISPLAY);
		cmd.next_row   = (cmd.tick_latch && stat.unit_zero) ||
		                 (cmd.tick_disp && stat.cd_last);
		cmd.pix_wr     = acc && (func == FUNC_PIXEL);
		cmd.fill_load  = acc && (func == FUNC_FILL);
		cmd.sweep_wr   = (mode_q != M_RUN);
		cmd.load_s1    = tick;
		cmd.load_out   = s1_valid_q && out_free;
	end

	assign out_valid = out_valid_q;

	// mode, scan phase and pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_CLEAR;
			phase_q     <= PH_SHIFT;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (mode_q) inside
				M_CLEAR, M_FILL: begin
					if (stat.sweep_last) begin
						mode_q <= M_RUN;
					end
				end
				M_RUN: begin
					if (cmd.fill_load) begin
						mode_q <= M_FILL;
					end
				end
				default: mode_q <= M_RUN;
			endcase

			if (tick) begin
				unique case (phase_q)
					PH_SHIFT: begin
						if (stat.col_last) begin
							phase_q <= PH_LATCH;
						end
					end
					PH_LATCH: begin
						phase_q <= stat.unit_zero ? PH_SHIFT : PH_DISPLAY;
					end
					PH_DISPLAY: begin
						if (stat.cd_last) begin
							phase_q <= PH_SHIFT;
						end
					end
					default: phase_q <= PH_SHIFT;
				endcase
			end

			if (tick) begin
				s1_valid_q <= 1'b1;
			end else if (cmd.load_out) begin
				s1_valid_q <= 1'b0;
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_disp_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISPLAY |-> stat.cd_nonzero)
		else $error("lit phase with empty countdown");

	a_latch_to_disp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_latch && !stat.unit_zero |=> phase_q == PH_DISPLAY)
		else $error("latch did not start lit period");

	a_fill_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_load |=> !in_ready)
		else $error("input open during fill sweep");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q)
		else $error("tick result dropped while output stalled");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != M_RUN && stat.sweep_last |=> mode_q == M_RUN)
		else $error("sweep did not return to run");

endmodule

/* sv/rgbm_dp.sv */
// datapath: scan counters, unit register, pixel store halves and result registers
module rgbm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rgbm_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  rgbm_pkg::ctrl_cmd_t  cmd,
	output rgbm_pkg::dp_stat_t   stat,
	output rgbm_pkg::out_item_t  out_data
);
	import rgbm_pkg::*;

	logic [UNIT_W-1:0]  unit_q;
	logic [PLANE_W-1:0] plane_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [CNT_W-1:0]   cd_q;
	logic [ROW_W-1:0]   held_q;
	logic [ADDR_W-1:0]  sweep_addr_q;
	pixel_t             sweep_colour_q;

	logic               is_shift_s1;
	logic               latch_s1;
	logic               up_ok_s1;
	logic               lo_ok_s1;
	logic [PLANE_W-1:0] bit_s1;
	logic [ROW_W-1:0]   row_addr_s1;
	out_item_t          out_q;

	logic               x_ok;
	logic               y_ok;
	logic               y_up;
	logic               y_lo;
	logic [15:0]        y_off;
	logic [ROW_W-1:0]   wr_row;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  ram_waddr;
	pixel_t             colour;
	pixel_t             ram_wdata;
	logic               up_we;
	logic               lo_we;
	logic [ADDR_W-1:0]  rd_addr;
	logic               up_ok;
	logic               lo_ok;
	logic [PIX_W-1:0]   up_rdata;
	logic [PIX_W-1:0]   lo_rdata;
	pixel_t             up_px;
	pixel_t             lo_px;

	// status toward the controller
	always_comb begin
		stat.col_last   = (col_q == COL_W'(PANEL_WIDTH - 1));
		stat.unit_zero  = (unit_q == '0);
		stat.cd_last    = (cd_q == CNT_W'(1));
		stat.cd_nonzero = (cd_q != '0);
		stat.sweep_last = (sweep_addr_q == ADDR_W'(MEM_DEPTH - 1));
	end

	// pixel write decode, each panel half has its own store
	always_comb begin
		colour    = '{red: in_data.red_level, green: in_data.green_level,
		              blue: in_data.blue_level};
		x_ok      = in_data.pixel_x < 16'(PANEL_WIDTH);
		y_ok      = in_data.pixel_y < 16'(PANEL_HEIGHT);
		y_up      = in_data.pixel_y < 16'(HALF_ROWS);
		y_off     = in_data.pixel_y - 16'(HALF_ROWS);
		y_lo      = !y_up && (y_off < 16'(HALF_ROWS));
		wr_row    = y_up ? in_data.pixel_y[ROW_W-1:0] : y_off[ROW_W-1:0];
		wr_addr   = pix_addr(wr_row, in_data.pixel_x[COL_W-1:0]);
		up_we     = cmd.sweep_wr || (cmd.pix_wr && x_ok && y_ok && y_up);
		lo_we     = cmd.sweep_wr || (cmd.pix_wr && x_ok && y_ok && y_lo);
		ram_waddr = cmd.sweep_wr ? sweep_addr_q : wr_addr;
		ram_wdata = cmd.sweep_wr ? sweep_colour_q : colour;
	end

	// scan read address and half validity
	always_comb begin
		rd_addr = pix_addr(row_q, col_q);
		up_ok   = {2'b00, row_q} < 7'(PANEL_HEIGHT);
		lo_ok   = ({2'b00, row_q} + 7'(HALF_ROWS)) < 7'(PANEL_HEIGHT);
	end

	rgbm_ram #(.WIDTH(PIX_W), .DEPTH(MEM_DEPTH)) u_upper_ram (
		.clk   (clk),
		.we    (up_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.tick_shift),
		.raddr (rd_addr),
		.rdata (up_rdata)
	);

	rgbm_ram #(.WIDTH(PIX_W), .DEPTH(MEM_DEPTH)) u_lower_ram (
		.clk   (clk),
		.we    (lo_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.tick_shift),
		.raddr (rd_addr),
		.rdata (lo_rdata)
	);

	// unit register, scan counters and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q         <= UNIT_RESET;
			plane_q        <= '0;
			row_q          <= '0;
			col_q          <= '0;
			cd_q           <= '0;
			held_q         <= '0;
			sweep_addr_q   <= '0;
			sweep_colour_q <= '0;
		end else begin
			if (cfg_we) begin
				unit_q <= cfg_wdata;
			end

			if (cmd.tick_shift) begin
				col_q <= stat.col_last ? '0 : col_q + COL_W'(1);
			end
			if (cmd.tick_latch) begin
				held_q <= row_q;
			end
			// lit countdown: loaded at latch, cleared when the row ends
			if (cmd.next_row) begin
				cd_q <= '0;
			end else if (cmd.tick_latch) begin
				cd_q <= CNT_W'(unit_q) << plane_q;
			end else if (cmd.tick_disp) begin
				cd_q <= cd_q - CNT_W'(1);
			end
			// advance to next scan row, wrapping into the next bit plane
			if (cmd.next_row) begin
				col_q <= '0;
				if (row_q == ROW_W'(HALF_ROWS - 1)) begin
					row_q   <= '0;
					plane_q <= (plane_q == PLANE_W'(PLANE_COUNT - 1)) ? '0 :
					           plane_q + PLANE_W'(1);
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end

			if (cmd.fill_load) begin
				sweep_colour_q <= colour;
			end
			if (cmd.sweep_wr) begin
				sweep_addr_q <= stat.sweep_last ? '0 : sweep_addr_q + ADDR_W'(1);
			end
		end
	end

	// first stage of a tick, waits on the ram read
	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			is_shift_s1 <= cmd.tick_shift;
			latch_s1    <= cmd.tick_latch;
			up_ok_s1    <= up_ok;
			lo_ok_s1    <= lo_ok;
			bit_s1      <= plane_q;
			row_addr_s1 <= cmd.tick_latch ? row_q : held_q;
		end
	end

	// result register, colour bits picked from the current plane
	always_comb begin
		up_px = pixel_t'(up_rdata);
		lo_px = pixel_t'(lo_rdata);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.upper_red      <= is_shift_s1 && up_ok_s1 && up_px.red[bit_s1];
			out_q.upper_green    <= is_shift_s1 && up_ok_s1 && up_px.green[bit_s1];
			out_q.upper_blue     <= is_shift_s1 && up_ok_s1 && up_px.blue[bit_s1];
			out_q.lower_red      <= is_shift_s1 && lo_ok_s1 && lo_px.red[bit_s1];
			out_q.lower_green    <= is_shift_s1 && lo_ok_s1 && lo_px.green[bit_s1];
			out_q.lower_blue     <= is_shift_s1 && lo_ok_s1 && lo_px.blue[bit_s1];
			out_q.shift_pulse    <= is_shift_s1;
			out_q.latch_strobe   <= latch_s1;
			out_q.output_disable <= is_shift_s1 || latch_s1;
			out_q.row_address    <= row_addr_s1;
		end
	end

	assign out_data = out_q;

endmodule

/* sv/rgb_matrix_bcm_scan_driver_top.sv */
// top level of the led matrix binary code modulation scan driver
//
// Input channel (in_valid/in_ready/in_data) carries three kinds of items:
// a scan tick, a single pixel write, or a fill of the whole framebuffer.
// Each scan tick yields one transfer on the output channel
// (out_valid/out_ready/out_data) with the panel pin levels for that step;
// pixel writes and fills yield nothing.
// Ticks and pixel writes are taken one per cycle unless input is held off;
// a tick result passes the ram read, then the result register.
// A fill writes both panel-half stores in parallel, one address per cycle,
// so input is held off until all MEM_DEPTH (2048) addresses are written;
// results already in flight keep draining meanwhile.
// After reset the same sweep clears the stores to zero, so input stays
// closed until that sweep ends; the unit register resets to 10.
// When the receiver stalls, the result register and one tick behind it
// hold, and input is taken again as soon as that slot frees.
// cfg_we/cfg_wdata write the lit-time unit; it is sampled at each latch.
module rgb_matrix_bcm_scan_driver_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rgbm_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rgbm_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata
);
	import rgbm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rgbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (in_data.func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rgbm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

/* test/tb_rgb_matrix_bcm_scan_driver_top.sv */
// testbench for the led matrix scan driver: directed and random items checked against a local scan model
module tb_rgb_matrix_bcm_scan_driver_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbm_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 2100;	// a fill may still be sweeping the store
	localparam int DRAIN_CYCLES  = 50;
	localparam int LONG_HOLD     = 600;
	localparam int HOLD_AT       = 150;

	// func code that the block ignores
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef enum logic [1:0] {SCAN_SHIFT, SCAN_LATCH, SCAN_LIT} scan_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	rgb_matrix_bcm_scan_driver_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// scan model state
	pixel_t      frame_buf [PANEL_HEIGHT][PANEL_WIDTH];
	logic [15:0] lit_unit;
	logic [2:0]  plane;
	int unsigned scan_row;
	int unsigned shift_col;
	scan_phase_t scan_phase;
	logic [22:0] lit_left;
	logic [4:0]  addr_held;

	in_item_t  pending_items [$];
	out_item_t expected_pins [$];

	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int results_seen = 0;
	in_item_t  next_item;
	out_item_t pins_want;
	out_item_t pins_got;

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_rgb_matrix_bcm_scan_driver_top failed");
			$finish;
		end
	end

	function automatic pixel_t pixel_from(int unsigned row, int unsigned col);
		if (row >= PANEL_HEIGHT || col >= PANEL_WIDTH)
			return '0;
		return frame_buf[row][col];
	endfunction

	// move on to the next scan row, wrapping into the next bit plane
	function automatic void advance_row();
		scan_phase = SCAN_SHIFT;
		shift_col = 0;
		lit_left = '0;
		scan_row++;
		if (scan_row >= HALF_ROWS) begin
			scan_row = 0;
			plane = (plane == PLANE_COUNT - 1) ? 3'd0 : plane + 3'd1;
		end
	endfunction

	// apply one accepted item to the model, queue the pin levels of a tick
	task automatic predict_scan_item(input in_item_t item);
		out_item_t   pins;
		pixel_t      up;
		pixel_t      lo;
		logic [31:0] lit_len;
		pins = '0;
		case (item.func)
			FUNC_PIXEL: begin
				if (item.pixel_x < PANEL_WIDTH && item.pixel_y < PANEL_HEIGHT)
					frame_buf[item.pixel_y][item.pixel_x] =
						'{item.red_level, item.green_level, item.blue_level};
			end
			FUNC_FILL: begin
				foreach (frame_buf[r, c])
					frame_buf[r][c] = '{item.red_level, item.green_level, item.blue_level};
			end
			FUNC_TICK: begin
				case (scan_phase)
					SCAN_LATCH: begin
						addr_held = 5'(scan_row);
						pins.latch_strobe = 1'b1;
						pins.output_disable = 1'b1;
						lit_len = {16'b0, lit_unit} << plane;
						if (lit_len == 0) begin
							advance_row();
						end else begin
							lit_left = lit_len[22:0];
							scan_phase = SCAN_LIT;
						end
					end
					SCAN_LIT: begin
						if (lit_left > 0)
							lit_left--;
						if (lit_left == 0)
							advance_row();
					end
					default: begin
						up = pixel_from(scan_row, shift_col);
						lo = pixel_from(scan_row + HALF_ROWS, shift_col);
						pins.upper_red   = up.red[plane];
						pins.upper_green = up.green[plane];
						pins.upper_blue  = up.blue[plane];
						pins.lower_red   = lo.red[plane];
						pins.lower_green = lo.green[plane];
						pins.lower_blue  = lo.blue[plane];
						pins.shift_pulse = 1'b1;
						pins.output_disable = 1'b1;
						if (shift_col == PANEL_WIDTH - 1) begin
							shift_col = 0;
							scan_phase = SCAN_LATCH;
						end else begin
							shift_col++;
						end
					end
				endcase
				pins.row_address = addr_held;
				expected_pins.push_back(pins);
			end
			default: ;
		endcase
	endtask

	// sender: bursts of transfers with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_scan_item(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					next_item = pending_items.pop_front();
					in_data <= next_item;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						// a long stretch with no idling
						burst_left = $urandom_range(60, 200);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = $urandom_range(0, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_pin(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// receiver: compare each result transfer, stall on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				pins_got = out_data;
				results_seen++;
				if (expected_pins.size() == 0) begin
					$display("%0t: result expected none, got %h", $time, pins_got);
					fail_count++;
				end else begin
					pins_want = expected_pins.pop_front();
					check_pin("upper_red", pins_want.upper_red, pins_got.upper_red);
					check_pin("upper_green", pins_want.upper_green, pins_got.upper_green);
					check_pin("upper_blue", pins_want.upper_blue, pins_got.upper_blue);
					check_pin("lower_red", pins_want.lower_red, pins_got.lower_red);
					check_pin("lower_green", pins_want.lower_green, pins_got.lower_green);
					check_pin("lower_blue", pins_want.lower_blue, pins_got.lower_blue);
					check_pin("shift_pulse", pins_want.shift_pulse, pins_got.shift_pulse);
					check_pin("latch_strobe", pins_want.latch_strobe, pins_got.latch_strobe);
					check_pin("output_disable", pins_want.output_disable,
						pins_got.output_disable);
					check_pin("row_address", pins_want.row_address, pins_got.row_address);
				end
				// one long hold-off so the block backs up into its input
				if (results_seen == HOLD_AT)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 300);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic void push_item(input logic [1:0] func, input logic [15:0] x,
			input logic [15:0] y, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		in_item_t item;
		item.func = func;
		item.pixel_x = x;
		item.pixel_y = y;
		item.red_level = r;
		item.green_level = g;
		item.blue_level = b;
		pending_items.push_back(item);
	endfunction

	// mostly ticks, with pixel writes, the odd fill and ignored codes
	function automatic in_item_t random_item(input int tick_pm, input int fill_pm);
		in_item_t item;
		int pick;
		item.pixel_x = 16'($urandom);
		item.pixel_y = 16'($urandom);
		item.red_level = 8'($urandom);
		item.green_level = 8'($urandom);
		item.blue_level = 8'($urandom);
		pick = $urandom_range(0, 999);
		if (pick < fill_pm) begin
			item.func = FUNC_FILL;
			if ($urandom_range(0, 3) == 0) begin
				item.red_level = '0;
				item.green_level = '0;
				item.blue_level = '0;
			end
		end else if (pick < fill_pm + 5) begin
			item.func = FUNC_NONE;
		end else if (pick < fill_pm + 5 + tick_pm) begin
			item.func = FUNC_TICK;
		end else begin
			item.func = FUNC_PIXEL;
			if ($urandom_range(0, 9) != 0) begin
				item.pixel_x = 16'($urandom_range(0, PANEL_WIDTH - 1));
				item.pixel_y = 16'($urandom_range(0, PANEL_HEIGHT - 1));
			end
		end
		return item;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_pins.size() != 0)
			@(negedge clk);
	endtask

	// optionally set the lit-time unit while idle, then queue random items
	task automatic run_phase(input bit set_unit, input logic [15:0] unit, input int count,
			input int tick_pm, input int fill_pm);
		if (set_unit) begin
			wait_idle();
			repeat (SETTLE_CYCLES) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= unit;
			@(posedge clk);
			cfg_we <= 1'b0;
			lit_unit = unit;
			@(negedge clk);
		end
		repeat (count)
			pending_items.push_back(random_item(tick_pm, fill_pm));
	endtask

	// stimulus and end of run
	initial begin
		foreach (frame_buf[r, c])
			frame_buf[r][c] = '0;
		lit_unit = UNIT_RESET;
		plane = '0;
		scan_row = 0;
		shift_col = 0;
		scan_phase = SCAN_SHIFT;
		lit_left = '0;
		addr_held = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: cleared store, fills, clear, pixel extremes, ignored writes
		push_item(FUNC_TICK, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
		push_item(FUNC_FILL, 16'd0, 16'd0, 8'ha5, 8'h5a, 8'h3c);
		push_item(FUNC_TICK, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_TICK, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
		push_item(FUNC_FILL, 16'd0, 16'd0, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_TICK, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
		push_item(FUNC_FILL, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
		push_item(FUNC_PIXEL, 16'd0, 16'd0, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_PIXEL, 16'd5, 16'd0, 8'hff, 8'h00, 8'hff);
		push_item(FUNC_PIXEL, 16'd6, 16'd32, 8'h00, 8'hff, 8'h00);
		push_item(FUNC_PIXEL, 16'd63, 16'd0, 8'h01, 8'h80, 8'hff);
		push_item(FUNC_PIXEL, 16'd63, 16'd63, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_PIXEL, 16'd64, 16'd0, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_PIXEL, 16'hffff, 16'd0, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_PIXEL, 16'd7, 16'd64, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_PIXEL, 16'd8, 16'hffff, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_PIXEL, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff);
		push_item(FUNC_NONE, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff);
		repeat (4)
			push_item(FUNC_TICK, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00);

		// reset unit, then the low extreme
		run_phase(1'b0, 16'd0, 250, 750, 10);
		run_phase(1'b1, 16'd1, 200, 800, 8);
		// zero unit, tick heavy so latch runs straight into the next row
		run_phase(1'b1, 16'd0, 400, 960, 2);
		run_phase(1'b1, 16'($urandom_range(2, 40)), 150, 700, 15);
		// high extreme last: its lit period is only entered, not finished
		run_phase(1'b1, 16'hffff, 130, 850, 10);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_rgb_matrix_bcm_scan_driver_top passed");
		else
			$display("tb_rgb_matrix_bcm_scan_driver_top failed");
		$finish;
	end

endmodule
